>>> rtl/core/stal_pkg.sv
// Shared types, character codes and a helper function for the ASCII line formatter.
`default_nettype none
package stal_pkg;

	// Number of axes in one sample.
	localparam int unsigned NUM_AXES = 3;

	// Number of binary-to-BCD shift steps for a 16-bit magnitude.
	localparam int unsigned NUM_STEPS = 16;

	// ASCII codes used in a line.
	localparam logic [7:0] CH_ZERO  = 8'd48;
	localparam logic [7:0] CH_MINUS = 8'd45;
	localparam logic [7:0] CH_COMMA = 8'd44;
	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_CR    = 8'd13;

	// One axis after classification: sign, digit presence and the low three BCD digits.
	typedef struct packed {
		logic       neg;
		logic       ge100;
		logic       ge10;
		logic [3:0] d2;
		logic [3:0] d1;
		logic [3:0] d0;
	} axis_fmt_t;

	// One queued line: all three axes of a sample.
	typedef struct packed {
		axis_fmt_t [NUM_AXES-1:0] ax;
	} line_ent_t;

	// Queue status seen by the front and back parts.
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// One double-dabble step on three BCD digits: adjust, then shift in a bit.
	// Carries out of the hundreds digit are dropped, which keeps the value mod 1000.
	function automatic logic [11:0] dd_step(input logic [11:0] bcd, input logic bit_in);
		logic [11:0] adj;
		adj = bcd;
		for (int i = 0; i < 3; i++) begin
			if (bcd[i*4 +: 4] >= 4'd5) begin
				adj[i*4 +: 4] = bcd[i*4 +: 4] + 4'd3;
			end
		end
		return {adj[10:0], bit_in};
	endfunction

endpackage
`default_nettype wire

>>> rtl/core/signed_triplet_to_ascii_line_unit.sv
// Top level of the signed triplet to ASCII line formatter.
// A sample is accepted when start is high and busy is low; busy stays high while converting.
// Conversion runs one shift step per cycle on all three axes at once.
// Bytes of a line then follow at one byte per cycle, 7 to 16 bytes per line.
// A two-line queue lets conversion of the next sample overlap the output of this one.
// Reset clears the sequencers and queue; no stale byte is emitted after reset.
`default_nettype none
module signed_triplet_to_ascii_line_unit (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic signed [15:0] axis_x,
	input  wire logic signed [15:0] axis_y,
	input  wire logic signed [15:0] axis_z,
	output logic                    char_strobe,
	output logic [7:0]              char_byte,
	output logic                    last_char
);

	stal_pkg::q_stat_t   q_stat;
	stal_pkg::line_ent_t push_ent;
	stal_pkg::line_ent_t head;
	logic                push;
	logic                pop;

	stal_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.axis_x   (axis_x),
		.axis_y   (axis_y),
		.axis_z   (axis_z),
		.q_stat   (q_stat),
		.push     (push),
		.push_ent (push_ent)
	);

	stal_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_ent (push_ent),
		.pop      (pop),
		.head     (head),
		.q_stat   (q_stat)
	);

	stal_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.q_stat      (q_stat),
		.pop         (pop),
		.char_strobe (char_strobe),
		.char_byte   (char_byte),
		.last_char   (last_char)
	);

endmodule
`default_nettype wire

>>> rtl/core/stal_front.sv
// Front part: accepts a sample, splits sign and magnitude and converts to BCD digits.
`default_nettype none
module stal_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire logic signed [15:0]  axis_x,
	input  wire logic signed [15:0]  axis_y,
	input  wire logic signed [15:0]  axis_z,
	input  wire stal_pkg::q_stat_t   q_stat,
	output logic                     push,
	output stal_pkg::line_ent_t      push_ent
);

	localparam logic [1:0] F_IDLE = 2'd0;
	localparam logic [1:0] F_CONV = 2'd1;
	localparam logic [1:0] F_DONE = 2'd2;

	logic [1:0]  state_q;
	logic [3:0]  cnt_q;
	logic        accept;
	logic [15:0] in_raw [stal_pkg::NUM_AXES];
	logic [15:0] mag    [stal_pkg::NUM_AXES];
	logic [15:0] bin_q  [stal_pkg::NUM_AXES];
	logic [11:0] bcd_q  [stal_pkg::NUM_AXES];
	logic        neg_q  [stal_pkg::NUM_AXES];
	logic        ge100_q[stal_pkg::NUM_AXES];
	logic        ge10_q [stal_pkg::NUM_AXES];

	// The part is busy while converting, or while a finished line waits for queue space.
	assign busy   = (state_q == F_CONV) || ((state_q == F_DONE) && q_stat.full);
	assign accept = start && !busy;
	assign push   = (state_q == F_DONE) && !q_stat.full;

	assign in_raw[0] = axis_x;
	assign in_raw[1] = axis_y;
	assign in_raw[2] = axis_z;

	// Magnitude of each axis; the most negative value maps to 0x8000.
	always_comb begin
		for (int i = 0; i < stal_pkg::NUM_AXES; i++) begin
			mag[i] = in_raw[i][15] ? (16'd0 - in_raw[i]) : in_raw[i];
		end
	end

	// Sequencer for the shared shift steps of all three lanes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cnt_q   <= 4'd0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (accept) begin
						state_q <= F_CONV;
						cnt_q   <= 4'd1;
					end
				end
				F_CONV: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'(stal_pkg::NUM_STEPS - 1)) begin
						state_q <= F_DONE;
					end
				end
				F_DONE: begin
					if (accept) begin
						state_q <= F_CONV;
						cnt_q   <= 4'd1;
					end else if (push) begin
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

	// Lane datapath: load performs the first shift step, then one step per cycle.
	always_ff @(posedge clk) begin
		for (int i = 0; i < stal_pkg::NUM_AXES; i++) begin
			if (accept) begin
				neg_q[i]   <= in_raw[i][15];
				ge100_q[i] <= (mag[i] >= 16'd100);
				ge10_q[i]  <= (mag[i] >= 16'd10);
				bcd_q[i]   <= {11'd0, mag[i][15]};
				bin_q[i]   <= {mag[i][14:0], 1'b0};
			end else if (state_q == F_CONV) begin
				bcd_q[i] <= stal_pkg::dd_step(bcd_q[i], bin_q[i][15]);
				bin_q[i] <= {bin_q[i][14:0], 1'b0};
			end
		end
	end

	// Pack the classified axes into a queue entry.
	always_comb begin
		for (int i = 0; i < stal_pkg::NUM_AXES; i++) begin
			push_ent.ax[i].neg   = neg_q[i];
			push_ent.ax[i].ge100 = ge100_q[i];
			push_ent.ax[i].ge10  = ge10_q[i];
			push_ent.ax[i].d2    = bcd_q[i][11:8];
			push_ent.ax[i].d1    = bcd_q[i][7:4];
			push_ent.ax[i].d0    = bcd_q[i][3:0];
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/stal_queue.sv
// Two-entry queue of converted lines between the front and back parts.
`default_nettype none
module stal_queue (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire stal_pkg::line_ent_t push_ent,
	input  wire logic                pop,
	output stal_pkg::line_ent_t      head,
	output stal_pkg::q_stat_t        q_stat
);

	stal_pkg::line_ent_t mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	assign q_stat.full  = (cnt_q == 2'd2);
	assign q_stat.empty = (cnt_q == 2'd0);
	assign do_push      = push && !q_stat.full;
	assign do_pop       = pop && !q_stat.empty;
	assign head         = mem_q[rd_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_q <= ~wr_q;
			end
			if (do_pop) begin
				rd_q <= ~rd_q;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_ent;
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/stal_back.sv
// Back part: walks a queued line and emits one ASCII beat per cycle while a line is in progress.
`default_nettype none
module stal_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire stal_pkg::line_ent_t head,
	input  wire stal_pkg::q_stat_t   q_stat,
	output logic                     pop,
	output logic                     char_strobe,
	output logic [7:0]               char_byte,
	output logic                     last_char
);

	localparam logic [2:0] P_IDLE = 3'd0;
	localparam logic [2:0] P_SIGN = 3'd1;
	localparam logic [2:0] P_D2   = 3'd2;
	localparam logic [2:0] P_D1   = 3'd3;
	localparam logic [2:0] P_D0   = 3'd4;
	localparam logic [2:0] P_SEP  = 3'd5;
	localparam logic [2:0] P_CR   = 3'd6;

	logic [2:0]          phase_q;
	logic [1:0]          axis_q;
	stal_pkg::line_ent_t cur_q;
	stal_pkg::axis_fmt_t cur_ax;
	stal_pkg::axis_fmt_t nxt_ax;
	logic [2:0]          phase_d;
	logic [1:0]          axis_d;
	logic [7:0]          byte_d;
	logic                strobe_q;
	logic [7:0]          char_q;
	logic                last_q;

	// First phase of an axis, skipping the absent sign and leading digits.
	function automatic logic [2:0] first_phase(input stal_pkg::axis_fmt_t a);
		if (a.neg) begin
			return P_SIGN;
		end else if (a.ge100) begin
			return P_D2;
		end else if (a.ge10) begin
			return P_D1;
		end
		return P_D0;
	endfunction

	// Current and following axis of the line being emitted.
	always_comb begin
		case (axis_q)
			2'd0: begin
				cur_ax = cur_q.ax[0];
				nxt_ax = cur_q.ax[1];
			end
			2'd1: begin
				cur_ax = cur_q.ax[1];
				nxt_ax = cur_q.ax[2];
			end
			default: begin
				cur_ax = cur_q.ax[2];
				nxt_ax = cur_q.ax[2];
			end
		endcase
	end

	// A new line is taken from the queue when idle or on the closing carriage return.
	assign pop = ((phase_q == P_IDLE) || (phase_q == P_CR)) && !q_stat.empty;

	// Next phase and axis.
	always_comb begin
		phase_d = phase_q;
		axis_d  = axis_q;
		case (phase_q)
			P_IDLE, P_CR: begin
				if (pop) begin
					phase_d = first_phase(head.ax[0]);
					axis_d  = 2'd0;
				end else begin
					phase_d = P_IDLE;
				end
			end
			P_SIGN: begin
				if (cur_ax.ge100) begin
					phase_d = P_D2;
				end else if (cur_ax.ge10) begin
					phase_d = P_D1;
				end else begin
					phase_d = P_D0;
				end
			end
			P_D2: begin
				phase_d = P_D1;
			end
			P_D1: begin
				phase_d = P_D0;
			end
			P_D0: begin
				phase_d = P_SEP;
			end
			P_SEP: begin
				if (axis_q == 2'(stal_pkg::NUM_AXES - 1)) begin
					phase_d = P_CR;
				end else begin
					phase_d = first_phase(nxt_ax);
					axis_d  = axis_q + 2'd1;
				end
			end
			default: begin
				phase_d = P_IDLE;
			end
		endcase
	end

	// Character for the current phase.
	always_comb begin
		case (phase_q)
			P_SIGN:  byte_d = stal_pkg::CH_MINUS;
			P_D2:    byte_d = stal_pkg::CH_ZERO + {4'd0, cur_ax.d2};
			P_D1:    byte_d = stal_pkg::CH_ZERO + {4'd0, cur_ax.d1};
			P_D0:    byte_d = stal_pkg::CH_ZERO + {4'd0, cur_ax.d0};
			P_SEP:   byte_d = (axis_q == 2'(stal_pkg::NUM_AXES - 1)) ?
					stal_pkg::CH_LF : stal_pkg::CH_COMMA;
			P_CR:    byte_d = stal_pkg::CH_CR;
			default: byte_d = stal_pkg::CH_CR;
		endcase
	end

	// Sequencer state and output strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= P_IDLE;
			axis_q   <= 2'd0;
			strobe_q <= 1'b0;
		end else begin
			phase_q  <= phase_d;
			axis_q   <= axis_d;
			strobe_q <= (phase_q != P_IDLE);
		end
	end

	// Working copy of the line and the output payload register.
	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
		if (phase_q != P_IDLE) begin
			char_q <= byte_d;
			last_q <= (phase_q == P_CR);
		end
	end

	assign char_strobe = strobe_q;
	assign char_byte   = char_q;
	assign last_char   = last_q;

endmodule
`default_nettype wire

>>> rtl/core/stal_port_chk.sv
// Port-level checks for the line formatter and their binding to the top level.
`default_nettype none
module stal_port_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        char_strobe,
	input wire logic [7:0]  char_byte,
	input wire logic        last_char
);

	// The closing flag only ever marks a carriage return.
	a_last_is_cr: assert property (@(posedge clk) disable iff (!arst_n)
		char_strobe && last_char |-> char_byte == stal_pkg::CH_CR)
		else $error("last_char set on a byte other than carriage return");

	// Every carriage return closes the line.
	a_cr_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		char_strobe && char_byte == stal_pkg::CH_CR |-> last_char)
		else $error("carriage return without last_char");

	// A line feed is followed directly by the closing carriage return.
	a_lf_then_cr: assert property (@(posedge clk) disable iff (!arst_n)
		char_strobe && char_byte == stal_pkg::CH_LF |=>
			char_strobe && char_byte == stal_pkg::CH_CR)
		else $error("line feed not followed by carriage return");

	// Busy only rises after a sample has been accepted.
	a_busy_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without an accepted beat");

endmodule

bind signed_triplet_to_ascii_line_unit stal_port_chk u_port_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.char_strobe (char_strobe),
	.char_byte   (char_byte),
	.last_char   (last_char)
);
`default_nettype wire
